// File: hdl/tww_pkg.sv
// ----------------------------------------------------------------------------
// tww_pkg
// Shared types and constants of the text word-wrap layout block.
// ----------------------------------------------------------------------------
package tww_pkg;

  // Fixed field widths
  localparam int COORD_W   = 12;
  localparam int CODE_W    = 7;
  localparam int CHAR_W    = 8;
  localparam int LC_W      = 6;
  localparam int SCALE_W   = 4;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  // Input actions
  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  // Special character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CODE_W-1:0] CH_SUBST   = 7'd63;

  // Result kinds
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_CHARS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd2;

  // Configuration reset values
  localparam logic [COORD_W-1:0] ORIGIN_X_RST   = 12'd20;
  localparam logic [LC_W-1:0]    LINE_CHARS_RST = 6'd48;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 4'd1;

  // Channel payloads
  typedef struct packed {
    logic [1:0]         action;
    logic [CHAR_W-1:0]  char_code;
    logic [COORD_W-1:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [CODE_W-1:0]  glyph_code;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               last;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT,
    ST_FINISH,
    ST_STORE,
    ST_REPORT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic begin_text;
    logic store;
    logic emit_start;
    logic emit_step;
    logic finish;
    logic report;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t act;
    logic    is_newline;
    logic    line_full;
    logic    line_open;
    logic    emit_done;
    logic    slot_free;
  } dp_status_t;

endpackage

// File: hdl/tww_ram.sv
// ----------------------------------------------------------------------------
// tww_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module tww_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 48
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/tww_ctrl.sv
// ----------------------------------------------------------------------------
// tww_ctrl
// Sequencer of the word-wrap block: decodes each item and steps the datapath
// through line emission, wrap bookkeeping, storing and the end report.
// ----------------------------------------------------------------------------
module tww_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tww_pkg::dp_status_t  st,
  output tww_pkg::ctrl_cmd_t   cmd
);
  import tww_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (st.act)
          ACT_BEGIN: begin
            cmd.begin_text = 1'b1;
            state_nxt      = ST_IDLE;
          end
          ACT_CHAR: begin
            if (st.is_newline || st.line_full) begin
              cmd.emit_start = 1'b1;
              state_nxt      = ST_EMIT;
            end else begin
              cmd.store = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          ACT_END: begin
            if (st.line_open) begin
              cmd.emit_start = 1'b1;
              state_nxt      = ST_EMIT;
            end else begin
              state_nxt = ST_REPORT;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EMIT: begin
        if (st.emit_done) begin
          state_nxt = ST_FINISH;
        end else if (st.slot_free) begin
          cmd.emit_step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        if (st.act == ACT_END) begin
          state_nxt = ST_REPORT;
        end else if (st.is_newline) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_REPORT: begin
        if (st.slot_free) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/tww_dp.sv
// ----------------------------------------------------------------------------
// tww_dp
// Datapath of the word-wrap block: configuration, line bookkeeping, the
// circular addressing of the line store, coordinates and the output stage.
// ----------------------------------------------------------------------------
module tww_dp #(
  parameter int MAX_LINE_CHARS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [tww_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [tww_pkg::CFG_W-1:0]              cfg_data,
  // input payload
  input  tww_pkg::in_item_t                      in_item,
  // controller
  input  tww_pkg::ctrl_cmd_t                     cmd,
  output tww_pkg::dp_status_t                    st,
  // line store
  output logic                                   ram_we,
  output logic [((MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1)-1:0] ram_waddr,
  output logic [tww_pkg::CODE_W-1:0]             ram_wdata,
  output logic                                   ram_re,
  output logic [((MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1)-1:0] ram_raddr,
  input  logic [tww_pkg::CODE_W-1:0]             ram_rdata,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output tww_pkg::out_item_t                     out_item
);
  import tww_pkg::*;

  localparam int AW = (MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1;
  localparam int CW = $clog2(MAX_LINE_CHARS + 1);
  localparam int SW = CW + 1;

  // Physical slot of a logical line position (base is the line's first slot)
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] b,
                                               input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(off);
    if (s >= SW'(MAX_LINE_CHARS)) begin
      s = s - SW'(MAX_LINE_CHARS);
    end
    return s[AW-1:0];
  endfunction

  // Saturating coordinate add
  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [7:0] b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + (COORD_W+1)'(b);
    return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
  endfunction

  // Configuration registers
  logic [COORD_W-1:0] origin_r;
  logic [LC_W-1:0]    lchars_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= ORIGIN_X_RST;
      lchars_r <= LINE_CHARS_RST;
      scale_r  <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ORIGIN_X:   origin_r <= cfg_data[COORD_W-1:0];
        REG_LINE_CHARS: lchars_r <= cfg_data[LC_W-1:0];
        REG_SCALE:      scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic [1:0]         act_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [COORD_W-1:0] sy_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_item.action;
      ch_r  <= in_item.char_code;
      sy_r  <= in_item.start_y;
    end
  end

  logic              is_nl, is_sp;
  logic [CODE_W-1:0] code7;
  assign is_nl = (ch_r == CH_NEWLINE);
  assign is_sp = (ch_r == CH_SPACE);
  assign code7 = ch_r[CHAR_W-1] ? CH_SUBST : ch_r[CODE_W-1:0];

  // Effective line width, clamped to 1..MAX_LINE_CHARS
  logic [CW-1:0] limit;
  always_comb begin
    if (lchars_r == '0) begin
      limit = CW'(1);
    end else if ({1'b0, lchars_r} > (LC_W+1)'(MAX_LINE_CHARS)) begin
      limit = CW'(MAX_LINE_CHARS);
    end else begin
      limit = CW'(lchars_r);
    end
  end

  // Glyph pitch 8*scale and line pitch 10*scale
  logic [7:0] xstep, rstep;
  assign xstep = {1'b0, scale_r, 3'b000};
  assign rstep = {1'b0, scale_r, 3'b000} + {3'b000, scale_r, 1'b0};

  // Line state
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      sidx_r, sidx_nxt;
  logic               sseen_r, sseen_nxt;
  logic               lopen_r, lopen_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [COORD_W-1:0] cursor_r, cursor_nxt;
  logic               store_ok;

  assign store_ok  = !(is_sp && (fill_r == '0)) && (fill_r < CW'(MAX_LINE_CHARS));
  assign ram_waddr = phys_addr(base_r, fill_r);
  assign ram_wdata = code7;

  always_comb begin
    fill_nxt   = fill_r;
    sidx_nxt   = sidx_r;
    sseen_nxt  = sseen_r;
    lopen_nxt  = lopen_r;
    base_nxt   = base_r;
    cursor_nxt = cursor_r;
    ram_we     = 1'b0;
    // begin text: new row, empty line
    if (cmd.begin_text) begin
      cursor_nxt = sy_r;
      fill_nxt   = '0;
      sidx_nxt   = '0;
      sseen_nxt  = 1'b0;
      lopen_nxt  = 1'b0;
    end
    // after a line went out: advance row, then carry the tail or close
    if (cmd.finish) begin
      cursor_nxt = sat_add(cursor_r, rstep);
      if ((act_r == ACT_CHAR) && !is_nl) begin
        if (sseen_r) begin
          base_nxt = phys_addr(base_r, sidx_r + CW'(1));
          fill_nxt = fill_r - sidx_r - CW'(1);
        end else begin
          fill_nxt = '0;
        end
      end else begin
        fill_nxt  = '0;
        lopen_nxt = 1'b0;
      end
      sidx_nxt  = '0;
      sseen_nxt = 1'b0;
    end
    // append the character; a leading space only opens the line
    if (cmd.store) begin
      lopen_nxt = 1'b1;
      if (store_ok) begin
        ram_we   = 1'b1;
        fill_nxt = fill_r + CW'(1);
        if (is_sp) begin
          sidx_nxt  = fill_r;
          sseen_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      sidx_r   <= '0;
      sseen_r  <= 1'b0;
      lopen_r  <= 1'b0;
      base_r   <= '0;
      cursor_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      sidx_r   <= sidx_nxt;
      sseen_r  <= sseen_nxt;
      lopen_r  <= lopen_nxt;
      base_r   <= base_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // Emission counter and running x coordinate
  logic [CW-1:0]      cnt_r, n_r;
  logic [COORD_W-1:0] xacc_r;
  logic               last_glyph;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r   <= '0;
    end else if (cmd.emit_start) begin
      cnt_r <= '0;
      n_r   <= ((act_r == ACT_CHAR) && !is_nl && sseen_r) ? sidx_r : fill_r;
    end else if (cmd.emit_step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      xacc_r <= origin_r;
    end else if (cmd.emit_step) begin
      xacc_r <= sat_add(xacc_r, xstep);
    end
  end

  assign last_glyph = (((CW+1)'(cnt_r) + (CW+1)'(1)) == (CW+1)'(n_r)) &&
                      (act_r != ACT_END);
  assign ram_re    = cmd.emit_step;
  assign ram_raddr = phys_addr(base_r, cnt_r);

  // Pending slot: a result waiting for the output register (a glyph's code is in the RAM read register)
  logic               pend_r;
  logic               pkind_r;
  logic [COORD_W-1:0] px_r, py_r;
  logic               plast_r;
  logic               ovalid_r;
  out_item_t          out_r;
  logic               mv;

  assign mv = pend_r && (!ovalid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (cmd.emit_step || cmd.report) begin
      pend_r <= 1'b1;
    end else if (mv) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      pkind_r <= KIND_GLYPH;
      px_r    <= xacc_r;
      py_r    <= cursor_r;
      plast_r <= last_glyph;
    end else if (cmd.report) begin
      pkind_r <= KIND_DONE;
      px_r    <= '0;
      py_r    <= cursor_r;
      plast_r <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (mv) begin
      ovalid_r <= 1'b1;
    end else if (!out_stall) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      out_r.kind       <= pkind_r;
      out_r.glyph_code <= (pkind_r == KIND_DONE) ? '0 : ram_rdata;
      out_r.pos_x      <= px_r;
      out_r.pos_y      <= py_r;
      out_r.last       <= plast_r;
    end
  end

  assign out_valid = ovalid_r;
  assign out_item  = out_r;

  // Status
  assign st.act        = action_t'(act_r);
  assign st.is_newline = is_nl;
  assign st.line_full  = (fill_r >= limit);
  assign st.line_open  = lopen_r;
  assign st.emit_done  = (cnt_r == n_r);
  assign st.slot_free  = !pend_r || mv;

endmodule

// File: hdl/text_word_wrap_layout_core.sv
// ----------------------------------------------------------------------------
// text_word_wrap_layout_core
// Greedy word-wrap layout of a character stream into glyph placements.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item): begin, character and end
//   items. One item is taken at a time; in_stall is high while it is worked.
//   Begin, an ignored action or a character that only appends returns to idle
//   after its decode. A line goes out one glyph per cycle, unless the result
//   channel stalls, from the line store's read port: a newline then finishes,
//   a wrapping character finishes and stores, and an end item with an open line
//   finishes and reports; an end item with no open line goes straight to report.
//   Result channel (out_valid / out_stall / out_item): an output register.
//   A glyph passes the RAM read register and the pending slot into it.
//   A stalled receiver holds the result; one more glyph waits in the RAM read
//   register, after which emission pauses. The next item is accepted while
//   results still wait.
//   Configuration (cfg_we / cfg_idx / cfg_data): write only while idle.
//   Reset: rst_n low (synchronous) restores origin 20, 48 chars, scale 1,
//   clears line state and the row cursor. The line store is not cleared.
// ----------------------------------------------------------------------------
module text_word_wrap_layout_core #(
  parameter int MAX_LINE_CHARS = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tww_pkg::in_item_t               in_item,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output tww_pkg::out_item_t              out_item,
  // configuration
  input  logic                            cfg_we,
  input  logic [tww_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tww_pkg::CFG_W-1:0]       cfg_data
);
  import tww_pkg::*;

  localparam int AW = (MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1;

  ctrl_cmd_t         cmd;
  dp_status_t        st;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CODE_W-1:0] ram_wdata, ram_rdata;

  // Sequencer
  tww_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath
  tww_dp #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Line store
  tww_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_LINE_CHARS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  // an accepted item makes the input side busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  // a RAM read is issued only when its result has somewhere to go
  a_step_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_step |-> st.slot_free)
    else $error("glyph read issued with pending slot occupied");

  // the end report is the final result of its item and carries no glyph
  a_report_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.kind == KIND_DONE)) |->
      (out_item.last && (out_item.glyph_code == '0) && (out_item.pos_x == '0)))
    else $error("malformed end report");
`endif

endmodule
